@@ design/tpsag_pkg.sv @@
// Types, constants and per-stage functions for the three-party shared gate.
// Used by three_party_shared_add_and_gate; no dependencies.
package tpsag_pkg;

    localparam int NUM_PARTIES    = 3;
    localparam int WORD_BITS      = 32;
    localparam int CARRY_BITS     = 31;
    localparam int BITS_PER_STAGE = 8;
    localparam int CARRY_STAGES   = (CARRY_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

    typedef enum logic
    {
        OP_AND = 1'b0,
        OP_ADD = 1'b1
    } gate_op_t;

    typedef logic [WORD_BITS-1:0]                  word_t;
    typedef logic [NUM_PARTIES-1:0][WORD_BITS-1:0] shares_t;

    // One gate in flight: operands, random words and the carry shares built so far
    typedef struct packed
    {
        gate_op_t op;
        shares_t  x;
        shares_t  y;
        shares_t  r;
        shares_t  c;
    } gate_t;

    typedef struct packed
    {
        gate_op_t op;
        shares_t  z;
        shares_t  view;
    } result_t;

    // Next party of p, wrapping around.
    function automatic int next_party(input int p);
        next_party = (p == NUM_PARTIES - 1) ? 0 : p + 1;
    endfunction

    // Advances the shared carry chain by up to BITS_PER_STAGE bits, starting at bit lo.
    function automatic gate_t carry_step(input gate_t g, input int lo);
        gate_t                  res;
        logic [NUM_PARTIES-1:0] a;
        logic [NUM_PARTIES-1:0] b;
        logic [4:0]             bi;
        int                     q;
        res = g;
        for (int j = 0; j < BITS_PER_STAGE; j++)
        begin
            if (lo + j < CARRY_BITS)
            begin
                bi = 5'(lo + j);
                for (int p = 0; p < NUM_PARTIES; p++)
                begin
                    a[p] = res.x[p][bi] ^ res.c[p][bi];
                    b[p] = res.y[p][bi] ^ res.c[p][bi];
                end
                for (int p = 0; p < NUM_PARTIES; p++)
                begin
                    q = next_party(p);
                    res.c[p][bi + 5'd1] = (a[p] & b[q]) ^ (a[q] & b[p]) ^ (a[p] & b[p])
                                        ^ res.c[p][bi] ^ res.r[p][bi] ^ res.r[q][bi];
                end
            end
        end
        carry_step = res;
    endfunction

    // Final result shares and view words from a gate whose carries are complete.
    function automatic result_t gate_result(input gate_t g);
        result_t res;
        word_t   t;
        int      q;
        res.op = g.op;
        for (int p = 0; p < NUM_PARTIES; p++)
        begin
            q = next_party(p);
            if (g.op == OP_ADD)
            begin
                res.z[p]    = g.x[p] ^ g.y[p] ^ g.c[p];
                res.view[p] = g.c[p];
            end
            else
            begin
                t = (g.x[p] & g.y[q]) ^ (g.x[q] & g.y[p]) ^ (g.x[p] & g.y[p])
                  ^ g.r[p] ^ g.r[q];
                res.z[p]    = t;
                res.view[p] = t;
            end
        end
        gate_result = res;
    endfunction

endpackage

@@ design/three_party_shared_add_and_gate.sv @@
// Three-party XOR-shared AND / ADD gate evaluator, top level.
// Depends on tpsag_pkg.
//
// Takes one gate per cycle while in_stall is low and raises out_valid with its result.
// The shared carry chain of ADD runs up to 8 bits per stage over four stages; an input
// register leads the pipeline and a result register ends it. Each stage advances whenever
// the stage after it is empty or moving, so bubbles close up and in_stall rises only when
// every stage holds a gate. AND passes through the same stages so results stay in order.
// Bit 31 of each random word is unused by ADD.
module three_party_shared_add_and_gate
    import tpsag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] x_party0,
    input  logic [31:0] x_party1,
    input  logic [31:0] x_party2,
    input  logic [31:0] y_party0,
    input  logic [31:0] y_party1,
    input  logic [31:0] y_party2,
    input  logic [31:0] r_party0,
    input  logic [31:0] r_party1,
    input  logic [31:0] r_party2,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] z_party0,
    output logic [31:0] z_party1,
    output logic [31:0] z_party2,
    output logic [31:0] view_party0,
    output logic [31:0] view_party1,
    output logic [31:0] view_party2
);

    gate_t                 gate_reg [0:CARRY_STAGES];
    logic [CARRY_STAGES:0] vld_reg;
    logic [CARRY_STAGES:0] ready;
    gate_t                 in_gate;
    gate_t                 gate_next [1:CARRY_STAGES];
    result_t               res_reg;
    result_t               res_next;
    logic                  out_vld_reg;
    logic                  out_ready;

    always_comb
    begin
        in_gate.op   = gate_op_t'(req_type);
        in_gate.x[0] = x_party0;
        in_gate.x[1] = x_party1;
        in_gate.x[2] = x_party2;
        in_gate.y[0] = y_party0;
        in_gate.y[1] = y_party1;
        in_gate.y[2] = y_party2;
        in_gate.r[0] = r_party0;
        in_gate.r[1] = r_party1;
        in_gate.r[2] = r_party2;
        in_gate.c    = '0;
    end

    // A stage can take a new transfer when it is empty or its content moves on.
    assign out_ready = !out_vld_reg || !out_stall;

    always_comb
    begin
        ready[CARRY_STAGES] = !vld_reg[CARRY_STAGES] || out_ready;
        for (int k = CARRY_STAGES - 1; k >= 0; k--)
        begin
            ready[k] = !vld_reg[k] || ready[k + 1];
        end
    end

    assign in_stall = !ready[0];

    always_comb
    begin
        for (int k = 1; k <= CARRY_STAGES; k++)
        begin
            gate_next[k] = carry_step(gate_reg[k - 1], (k - 1) * BITS_PER_STAGE);
        end
    end

    assign res_next = gate_result(gate_reg[CARRY_STAGES]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (ready[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k <= CARRY_STAGES; k++)
            begin
                if (ready[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
            if (out_ready)
            begin
                out_vld_reg <= vld_reg[CARRY_STAGES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            gate_reg[0] <= in_gate;
        end
        for (int k = 1; k <= CARRY_STAGES; k++)
        begin
            if (ready[k] && vld_reg[k - 1])
            begin
                gate_reg[k] <= gate_next[k];
            end
        end
        if (out_ready && vld_reg[CARRY_STAGES])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign z_party0    = res_reg.z[0];
    assign z_party1    = res_reg.z[1];
    assign z_party2    = res_reg.z[2];
    assign view_party0 = res_reg.view[0];
    assign view_party1 = res_reg.view[1];
    assign view_party2 = res_reg.view[2];

    // The input side stalls only with the first stage occupied.
    a_stall_needs_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> vld_reg[0])
        else $error("in_stall raised with an empty input stage");

    // A gate in the last carry stage reaches the result register next cycle when out_ready is high.
    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CARRY_STAGES] && out_ready |=> out_vld_reg)
        else $error("gate lost between last carry stage and result register");

    // AND results equal their view words.
    a_and_view: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.op == OP_AND |-> res_reg.view == res_reg.z)
        else $error("AND view word differs from result share");

    // ADD carry bit 0 is always zero.
    a_add_carry0: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.op == OP_ADD
        |-> !res_reg.view[0][0] && !res_reg.view[1][0] && !res_reg.view[2][0])
        else $error("ADD carry share bit 0 not zero");

endmodule
